// File: rtl/core/mhb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap builder package
// Shared widths and the default capacity of the sift-down unit and the
// element store, and the signed compare used by the sift-down unit.
// ----------------------------------------------------------------------------
package mhb_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef logic signed [DATA_W-1:0] t_data;

    // Signed less-than; the single comparator of the sift-down unit.
    function automatic logic lt_s(input t_data a, input t_data b);
        return a < b;
    endfunction

endpackage

// File: rtl/core/min_heap_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bottom-up binary min-heap builder
// Collects signed values, rearranges them into a min-heap by sift-down from
// the last parent to the root, then emits the array in index order.
// ----------------------------------------------------------------------------
// Usage:
// Input requests (i_in_valid / o_in_stall) carry one value each. Requests
// beyond MAX_ITEMS are dropped, but a marked one still starts the build.
// The request with i_last_item set starts the build, and o_in_stall stays
// high from then until the last result has been taken. For each parent,
// from the last down to the root, the build reads the node, compares the
// children, compares the chosen child with the sifted value and writes the
// value back, repeating both compares for each level that it moves down,
// all on one comparator and the store's single write port. Results
// (o_out_valid / i_out_stall) follow in index order, one at a time: each is
// a registered store read that starts once the one before has been taken.
// A stalled result holds in the output register. o_last_result marks the
// final one. Reset empties the block; the store needs no clearing.
// ----------------------------------------------------------------------------
module min_heap_build #(
    parameter int MAX_ITEMS = mhb_pkg::MAX_ITEMS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mhb_pkg::t_data i_value,
    input  logic           i_last_item,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mhb_pkg::t_data o_heap_value,
    output logic           o_last_result
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_RD_NODE   = 4'd1;
    localparam logic [3:0] S_LD_CUR    = 4'd2;
    localparam logic [3:0] S_CMP_LR    = 4'd3;
    localparam logic [3:0] S_CMP_CUR   = 4'd4;
    localparam logic [3:0] S_PUT       = 4'd5;
    localparam logic [3:0] S_EMIT_RD   = 4'd6;
    localparam logic [3:0] S_EMIT_LD   = 4'd7;
    localparam logic [3:0] S_EMIT_HOLD = 4'd8;

    logic [3:0]     r_state,     n_state;
    logic [CW-1:0]  r_count,     n_count;
    logic [CW-1:0]  r_start,     n_start;
    logic [CW-1:0]  r_node,      n_node;
    logic [CW-1:0]  r_idx,       n_idx;
    logic [CW-1:0]  r_sel_idx,   n_sel_idx;
    logic           r_both,      n_both;
    mhb_pkg::t_data r_cur,       n_cur;
    mhb_pkg::t_data r_sel_val,   n_sel_val;
    logic           r_out_valid, n_out_valid;
    mhb_pkg::t_data r_out_val,   n_out_val;
    logic           r_out_last,  n_out_last;

    logic           we;
    logic [AW-1:0]  waddr;
    mhb_pkg::t_data wdata;
    logic [AW-1:0]  raddr_a;
    logic [AW-1:0]  raddr_b;
    mhb_pkg::t_data rdata_a;
    mhb_pkg::t_data rdata_b;

    mhb_pkg::t_data cmp_a;
    mhb_pkg::t_data cmp_b;
    logic           cmp_lt;

    logic           in_acc;
    logic           has_room;
    logic [CW-1:0]  cnt_new;
    logic [CW-1:0]  half;
    logic [CW-1:0]  left_idx;
    logic [CW-1:0]  right_idx;
    logic [CW-1:0]  sel_left;
    logic [CW-1:0]  sel_right;
    logic           take_child;

    mhb_mem #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign in_acc    = i_in_valid && !o_in_stall;
    assign has_room  = (r_count < CW'(MAX_ITEMS));
    assign cnt_new   = r_count + CW'(has_room);
    assign half      = r_count >> 1;
    assign left_idx  = CW'({r_node, 1'b1});
    assign right_idx = left_idx + CW'(1);
    assign sel_left  = CW'({r_sel_idx, 1'b1});
    assign sel_right = sel_left + CW'(1);

    // The one comparator: left against right first, then the chosen child
    // against the value being sifted. With only a left child the parent
    // moves down when the child is not greater, so the operands swap.
    always_comb begin
        cmp_a = rdata_a;
        cmp_b = rdata_b;
        if (r_state == S_CMP_CUR) begin
            cmp_a = r_both ? r_sel_val : r_cur;
            cmp_b = r_both ? r_cur : r_sel_val;
        end
    end

    assign cmp_lt     = mhb_pkg::lt_s(cmp_a, cmp_b);
    assign take_child = r_both ? cmp_lt : !cmp_lt;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_start     = r_start;
        n_node      = r_node;
        n_idx       = r_idx;
        n_sel_idx   = r_sel_idx;
        n_both      = r_both;
        n_cur       = r_cur;
        n_sel_val   = r_sel_val;
        n_out_valid = r_out_valid;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        we          = 1'b0;
        waddr       = r_node[AW-1:0];
        wdata       = r_cur;
        raddr_a     = r_node[AW-1:0];
        raddr_b     = r_node[AW-1:0];

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    we      = has_room;
                    waddr   = r_count[AW-1:0];
                    wdata   = i_value;
                    n_count = cnt_new;
                    if (i_last_item) begin
                        if (cnt_new < CW'(2)) begin
                            n_idx   = '0;
                            n_state = S_EMIT_RD;
                        end else begin
                            n_start = (cnt_new >> 1) - CW'(1);
                            n_node  = (cnt_new >> 1) - CW'(1);
                            n_state = S_RD_NODE;
                        end
                    end
                end
            end
            S_RD_NODE: begin
                raddr_a = r_node[AW-1:0];
                n_state = S_LD_CUR;
            end
            S_LD_CUR: begin
                n_cur   = rdata_a;
                raddr_a = left_idx[AW-1:0];
                raddr_b = right_idx[AW-1:0];
                n_state = S_CMP_LR;
            end
            S_CMP_LR: begin
                // On a tie the right child is the candidate.
                if (right_idx < r_count) begin
                    n_both    = 1'b1;
                    n_sel_idx = cmp_lt ? left_idx : right_idx;
                    n_sel_val = cmp_lt ? rdata_a : rdata_b;
                end else begin
                    n_both    = 1'b0;
                    n_sel_idx = left_idx;
                    n_sel_val = rdata_a;
                end
                n_state = S_CMP_CUR;
            end
            S_CMP_CUR: begin
                if (take_child) begin
                    // The child moves up; the sifted value stays in r_cur.
                    we      = 1'b1;
                    waddr   = r_node[AW-1:0];
                    wdata   = r_sel_val;
                    n_node  = r_sel_idx;
                    raddr_a = sel_left[AW-1:0];
                    raddr_b = sel_right[AW-1:0];
                    n_state = (r_sel_idx < half) ? S_CMP_LR : S_PUT;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                we    = 1'b1;
                waddr = r_node[AW-1:0];
                wdata = r_cur;
                if (r_start == '0) begin
                    n_idx   = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_start = r_start - CW'(1);
                    n_node  = r_start - CW'(1);
                    n_state = S_RD_NODE;
                end
            end
            S_EMIT_RD: begin
                raddr_a = r_idx[AW-1:0];
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_out_val   = rdata_a;
                n_out_last  = ((r_idx + CW'(1)) == r_count);
                n_out_valid = 1'b1;
                n_state     = S_EMIT_HOLD;
            end
            S_EMIT_HOLD: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_count = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state     = S_LOAD;
                n_count     = '0;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_node     <= n_node;
        r_idx      <= n_idx;
        r_sel_idx  <= n_sel_idx;
        r_both     <= n_both;
        r_cur      <= n_cur;
        r_sel_val  <= n_sel_val;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
    end

    assign o_in_stall    = (r_state != S_LOAD);
    assign o_out_valid   = r_out_valid;
    assign o_heap_value  = r_out_val;
    assign o_last_result = r_out_last;

endmodule

// File: rtl/core/mhb_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap builder element store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mhb_mem #(
    parameter int DEPTH = mhb_pkg::MAX_ITEMS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  mhb_pkg::t_data    i_wdata,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output mhb_pkg::t_data    o_rdata_a,
    output mhb_pkg::t_data    o_rdata_b
);

    mhb_pkg::t_data r_mem [DEPTH];
    mhb_pkg::t_data r_rdata_a;
    mhb_pkg::t_data r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: verif/tb_min_heap_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap builder testbench
// Sends sets of signed values to min_heap_build. For each marked request the
// heap-ordered array is predicted here and every emitted element is checked
// in order. Both handshakes carry random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_min_heap_build;
    import mhb_pkg::*;

    localparam int CAPACITY     = MAX_ITEMS_DEF;
    localparam int ITEM_TARGET  = 260;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        t_data value;
        logic  last;
    } t_heap_entry;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_stall;
    t_data i_value;
    logic  i_last_item;
    logic  o_out_valid;
    logic  i_out_stall;
    t_data o_heap_value;
    logic  o_last_result;

    t_data       set_store[CAPACITY];
    int          set_count      = 0;
    t_heap_entry expected_heap[$];
    int          mismatch_count = 0;
    int          requests_sent  = 0;
    int          idle_cycles    = 0;
    bit          send_steady    = 1'b0;
    bit          take_steady    = 1'b0;

    min_heap_build #(
        .MAX_ITEMS(CAPACITY)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_last_item  (i_last_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_heap_value (o_heap_value),
        .o_last_result(o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // With two children a parent moves down only past a strictly smaller one, with a single
    // child also past an equal one; on equal children the right one is the candidate.
    function automatic void sift_down_at(input int n, input int start);
        int    node;
        int    left;
        int    right;
        int    smaller;
        int    pick;
        t_data tmp;
        bit    settled;
        node    = start;
        settled = 1'b0;
        while (!settled && node < n / 2) begin
            left  = 2 * node + 1;
            right = left + 1;
            if (right >= n) begin
                pick = (set_store[node] < set_store[left]) ? node : left;
            end else begin
                smaller = (set_store[left] < set_store[right]) ? left : right;
                pick    = (set_store[smaller] < set_store[node]) ? smaller : node;
            end
            if (pick == node) begin
                settled = 1'b1;
            end else begin
                tmp             = set_store[node];
                set_store[node] = set_store[pick];
                set_store[pick] = tmp;
                node            = pick;
            end
        end
    endfunction

    function automatic void accept_element(input t_data val, input logic last);
        t_heap_entry entry;
        int          i;
        if (set_count < CAPACITY) begin
            set_store[set_count] = val;
            set_count++;
        end
        if (last) begin
            for (i = set_count / 2; i > 0; i--)
                sift_down_at(set_count, i - 1);
            for (i = 0; i < set_count; i++) begin
                entry.value = set_store[i];
                entry.last  = (i == set_count - 1);
                expected_heap.push_back(entry);
            end
            set_count = 0;
        end
    endfunction

    // Small values give plenty of ties; the rest sit near the extremes or
    // spread over the whole range.
    function automatic t_data draw_value();
        int unsigned pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0, 1: begin
                draw_value = t_data'(int'($urandom_range(0, 8)) - 4);
            end
            2: begin
                draw_value = t_data'(32'h8000_0000 + $urandom_range(0, 3));
            end
            3: begin
                draw_value = t_data'(32'h7FFF_FFFF - $urandom_range(0, 3));
            end
            default: begin
                draw_value = t_data'($urandom);
            end
        endcase
    endfunction

    // Called straight after the previous acceptance, so the first negedge
    // here is a fresh time step and valid is never lowered and raised at once.
    task automatic send_element(input t_data val, input logic last);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_value     <= val;
        i_last_item <= last;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        accept_element(val, last);
        requests_sent++;
    endtask

    task automatic send_set(input t_data vals[$]);
        int i;
        send_steady = ($urandom_range(0, 3) == 0);
        for (i = 0; i < vals.size(); i++)
            send_element(vals[i], i == vals.size() - 1);
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_heap.size() == 0);
    endtask

    task automatic test_value_extremes();
        t_data vals[$];
        vals = {t_data'(32'h7FFF_FFFF), t_data'(0), t_data'(-1),
                t_data'(1), t_data'(32'h8000_0001), t_data'(32'h8000_0000)};
        send_set(vals);
    endtask

    task automatic test_single_element();
        t_data vals[$];
        vals = {draw_value()};
        send_set(vals);
    endtask

    task automatic test_left_child_only();
        t_data vals[$];
        vals = {t_data'(5), t_data'(5)};
        send_set(vals);
        vals = {t_data'(7), t_data'(3)};
        send_set(vals);
        // The last parent has a single child equal to itself.
        vals = {t_data'(9), t_data'(6), t_data'(1), t_data'(6)};
        send_set(vals);
    endtask

    task automatic test_equal_children();
        t_data vals[$];
        // The root follows the right child, which shows in the final order.
        vals = {t_data'(9), t_data'(4), t_data'(4), t_data'(5),
                t_data'(6), t_data'(7), t_data'(8)};
        send_set(vals);
        vals = {t_data'(3), t_data'(3), t_data'(3), t_data'(3)};
        send_set(vals);
    endtask

    task automatic test_store_full();
        t_data vals[$];
        repeat (CAPACITY) vals.push_back(draw_value());
        send_set(vals);
        // Requests beyond capacity are dropped, but the marked one still
        // starts the build of what is held.
        vals.delete();
        repeat (CAPACITY + 3) vals.push_back(draw_value());
        send_set(vals);
    endtask

    task automatic test_random_sets();
        t_data vals[$];
        int    size;
        int    sets;
        sets = 0;
        while (requests_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0)
                size = $urandom_range(13, 40);
            else
                size = $urandom_range(1, 12);
            if (size > ITEM_TARGET - requests_sent)
                size = ITEM_TARGET - requests_sent;
            vals.delete();
            repeat (size) vals.push_back(draw_value());
            send_set(vals);
            sets++;
            if (sets == 3)
                hold_until_drained();
        end
    endtask

    initial begin : result_check
        t_heap_entry want;
        int          gap;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 15) == 0)
                take_steady = !take_steady;
            gap = take_steady ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            if (expected_heap.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", o_heap_value));
            end else begin
                want = expected_heap.pop_front();
                if (o_heap_value !== want.value)
                    report_mismatch($sformatf("heap_value %0d, expected %0d",
                                              o_heap_value, want.value));
                if (o_last_result !== want.last)
                    report_mismatch($sformatf("last_result %b, expected %b",
                                              o_last_result, want.last));
            end
        end
    end

    // Ends a hung run: no request accepted on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("min_heap_build verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_value     = '0;
        i_last_item = 1'b0;
        i_out_stall = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_value_extremes();
        test_single_element();
        test_left_child_only();
        test_equal_children();
        test_store_full();
        test_random_sets();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_heap.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_heap.size() != 0)
            report_mismatch("results still outstanding at the end");
        if (mismatch_count == 0)
            $display("min_heap_build verification clean");
        else
            $display("min_heap_build verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mhb_pkg.sv
rtl/core/mhb_mem.sv
rtl/core/min_heap_build.sv
verif/tb_min_heap_build.sv
